// File: design/mwul_pkg.sv
// Shared types and constants for the max window under limit tracker.
package mwul_pkg;

    // Fixed widths of the stream fields.
    localparam int SAMPLE_FIELD_W = 16;
    localparam int WINDOW_LEN_W   = 11;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a new word is taken from the input stream
        logic rd;        // issue a ring read
        logic slide;     // finish a slide with the ring data just read
        logic drop;      // drop the oldest sample with the ring data just read
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;   // the offered word slides the window
        logic over_now;    // window is not empty and its sum exceeds the limit
        logic over_after;  // still over the limit after the current drop
    } t_stat;

endpackage

// File: design/mwul_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mwul_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/mwul_dp.sv
// Datapath of the window tracker: window sum, length, ring pointers and sample ring.
module mwul_dp #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [31:0]                          i_cfg_wr_data,
    input  logic [mwul_pkg::SAMPLE_FIELD_W-1:0]  i_sample,
    input  logic                                 i_last,
    input  mwul_pkg::t_cmd                       i_cmd,
    output mwul_pkg::t_stat                      o_stat,
    output logic [mwul_pkg::WINDOW_LEN_W-1:0]    o_window_len,
    output logic                                 o_final,
    output logic                                 o_capped
);

    import mwul_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int CMP_W = (SUM_W + 1 > 32) ? SUM_W + 1 : 32;

    // Stream state.
    logic [SUM_W-1:0]       r_sum,     n_sum;
    logic [LEN_W-1:0]       r_len,     n_len;
    logic [PTR_W-1:0]       r_head,    n_head;
    logic [PTR_W-1:0]       r_tail,    n_tail;
    logic                   r_growing, n_growing;
    logic                   r_cap,     n_cap;
    logic [31:0]            r_limit;

    // Latched word and result payload.
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_last;
    logic [WINDOW_LEN_W-1:0] r_out_len;
    logic                   r_out_final;
    logic                   r_out_cap;

    logic [SAMPLE_BITS-1:0] x_in;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   case_a;
    logic                   case_b;
    logic                   fits;
    logic                   first_over;
    logic                   len_full;
    logic [PTR_W-1:0]       head_inc;
    logic [PTR_W-1:0]       tail_inc;
    logic [SUM_W-1:0]       sum_slide;
    logic [SUM_W-1:0]       sum_drop;
    logic [LEN_W-1:0]       len_dec;
    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [PTR_W-1:0]       rd_addr;

    // Decode the offered word against the current window.
    always_comb begin
        x_in       = SAMPLE_BITS'(i_sample);
        case_a     = r_growing && (r_len == '0);
        fits       = (CMP_W'(r_sum) + CMP_W'(x_in)) <= CMP_W'(r_limit);
        case_b     = r_growing && !case_a && fits;
        len_full   = (r_len == LEN_W'(WINDOW_MAX));
        first_over = CMP_W'(x_in) > CMP_W'(r_limit);
        head_inc   = (r_head == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_head + 1'b1;
        tail_inc   = (r_tail == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_tail + 1'b1;
        sum_slide  = r_sum - SUM_W'(rd_data) + SUM_W'(r_x);
        sum_drop   = r_sum - SUM_W'(rd_data);
        len_dec    = r_len - 1'b1;
    end

    // Status toward the controller.
    always_comb begin
        o_stat.need_read  = !case_a && (case_b ? len_full : (r_len != '0));
        o_stat.over_now   = (r_len != '0) && (CMP_W'(r_sum) > CMP_W'(r_limit));
        o_stat.over_after = (len_dec != '0) && (CMP_W'(sum_drop) > CMP_W'(r_limit));
    end

    // Ring access: writes always go to the head, reads to the oldest slot.
    always_comb begin
        wr_en   = (i_cmd.accept && (case_a || (case_b && !len_full))) || i_cmd.slide;
        wr_data = i_cmd.accept ? x_in : r_x;
        rd_addr = i_cmd.drop ? tail_inc : r_tail;
    end

    mwul_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next value of the stream state.
    always_comb begin
        n_sum     = r_sum;
        n_len     = r_len;
        n_head    = r_head;
        n_tail    = r_tail;
        n_growing = r_growing;
        n_cap     = r_cap;
        if (i_cmd.accept) begin
            if (case_a) begin
                // The first sample is always taken, and dropped again if alone it is too big.
                n_head = head_inc;
                if (first_over) begin
                    n_sum     = '0;
                    n_len     = '0;
                    n_tail    = tail_inc;
                    n_growing = 1'b0;
                end else begin
                    n_sum = SUM_W'(x_in);
                    n_len = LEN_W'(1);
                end
            end else if (case_b) begin
                if (!len_full) begin
                    n_sum  = r_sum + SUM_W'(x_in);
                    n_len  = r_len + 1'b1;
                    n_head = head_inc;
                end else begin
                    n_cap = 1'b1;
                end
            end else begin
                n_growing = 1'b0;
            end
        end else if (i_cmd.slide) begin
            n_sum  = sum_slide;
            n_head = head_inc;
            n_tail = tail_inc;
        end else if (i_cmd.drop) begin
            n_sum  = sum_drop;
            n_len  = len_dec;
            n_tail = tail_inc;
        end else if (i_cmd.load_out && r_last) begin
            // End of stream: back to the start of a new one.
            n_sum     = '0;
            n_len     = '0;
            n_head    = '0;
            n_tail    = '0;
            n_growing = 1'b1;
            n_cap     = 1'b0;
        end
    end

    // Stream state and limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_len     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_growing <= 1'b1;
            r_cap     <= 1'b0;
            r_limit   <= '0;
        end else begin
            r_sum     <= n_sum;
            r_len     <= n_len;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_growing <= n_growing;
            r_cap     <= n_cap;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers: latched word and the result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x    <= x_in;
            r_last <= i_last;
        end
        if (i_cmd.load_out) begin
            r_out_len   <= WINDOW_LEN_W'(r_len);
            r_out_final <= r_last;
            r_out_cap   <= r_cap;
        end
    end

    assign o_window_len = r_out_len;
    assign o_final      = r_out_final;
    assign o_capped     = r_out_cap;

endmodule

// File: design/mwul_ctrl.sv
// Controller of the window tracker: sequences accept, slide, drops and result hand-off.
module mwul_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  mwul_pkg::t_stat i_stat,
    output mwul_pkg::t_cmd  o_cmd
);

    import mwul_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_CHECK,
        ST_DROP,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Command decode and next state.
    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        o_cmd          = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd     = i_stat.need_read;
                    n_state      = i_stat.need_read ? ST_SLIDE : ST_DONE;
                end
            end
            ST_SLIDE: begin
                o_cmd.slide = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.over_now) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_DROP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DROP: begin
                o_cmd.drop = 1'b1;
                if (i_stat.over_after) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/max_window_under_limit_top.sv
// Top level of the max window under limit tracker.
// Each input word gives one result word. A word that grows the window goes from accept
// straight to the result state; a word that slides it passes the slide and check states
// and then drops samples from the old end one at a time, as the sample ring has a single read port.
// A full result register that is not taken holds the controller before the next accept.
// Reset is synchronous and active low; it clears the stream state and the limit.
// The sample ring is not cleared, so no clearing pass follows reset.
module max_window_under_limit_top #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [31:0]                         i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mwul_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [15:0] sample
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mwul_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [10:0] window_len, rest zero
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser    // [0] capped
);

    import mwul_pkg::*;

    t_cmd                    cmd;
    t_stat                   stat;
    logic [WINDOW_LEN_W-1:0] window_len;

    mwul_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mwul_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (s_axis_tdata[SAMPLE_FIELD_W-1:0]),
        .i_last        (s_axis_tlast),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_window_len  (window_len),
        .o_final       (m_axis_tlast),
        .o_capped      (m_axis_tuser)
    );

    // Pack the result word.
    assign m_axis_tdata = OUT_TDATA_W'(window_len);

endmodule
